@@ rtl/plt_pkg.sv @@
// Package for the proximity link tracker: word types, codes and helpers.
`default_nettype none
package plt_pkg;
	localparam int MAX_DEVICES = 32;
	localparam int SLOT_W = 5;
	localparam int COORD_W = 16;
	localparam int RADIUS_W = 16;
	localparam int SQ_W = 33;
	localparam int D2_W = 35;

	localparam logic [1:0] ACT_CREATE = 2'd0;
	localparam logic [1:0] ACT_UPDATE = 2'd1;
	localparam logic [1:0] ACT_DESTROY = 2'd2;

	localparam logic [1:0] POS_PREV = 2'd1;
	localparam logic [1:0] POS_NEXT = 2'd2;

	localparam logic [1:0] EVT_NONE = 2'd0;
	localparam logic [1:0] EVT_MADE = 2'd1;
	localparam logic [1:0] EVT_LOST = 2'd2;
	localparam logic [1:0] EVT_DUP = 2'd3;

	localparam logic REG_CONNECT = 1'b0;
	localparam logic REG_DISCONNECT = 1'b1;

	typedef struct packed {
		logic [1:0] action;
		logic [4:0] device_slot;
		logic reader_role;
		logic [1:0] position_kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
	} req_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [4:0] reader_slot;
		logic [4:0] tag_slot;
		logic last;
	} evt_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} pos_t;

	typedef struct packed {
		logic near;
		logic far;
	} cmp_t;

	function automatic logic [SLOT_W-1:0] lowest_idx(input logic [MAX_DEVICES-1:0] m);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = MAX_DEVICES - 1; i >= 0; i--) begin
			if (m[i]) r = SLOT_W'(i);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/plt_dist.sv @@
// Two-stage squared distance and radius compare.
`default_nettype none
module plt_dist import plt_pkg::*; (
	input wire logic clk,
	input wire pos_t self_pos,
	input wire pos_t peer_pos,
	input wire logic [2*RADIUS_W-1:0] cr2,
	input wire logic [2*RADIUS_W-1:0] dr2,
	output cmp_t cmp
);
	logic signed [COORD_W:0] dx, dy, dz;
	logic signed [2*COORD_W+1:0] px, py, pz;
	logic [SQ_W-1:0] sx_s2, sy_s2, sz_s2;
	logic [D2_W-1:0] d2;

	assign dx = {self_pos.x[COORD_W-1], self_pos.x} - {peer_pos.x[COORD_W-1], peer_pos.x};
	assign dy = {self_pos.y[COORD_W-1], self_pos.y} - {peer_pos.y[COORD_W-1], peer_pos.y};
	assign dz = {self_pos.z[COORD_W-1], self_pos.z} - {peer_pos.z[COORD_W-1], peer_pos.z};
	assign px = dx * dx;
	assign py = dy * dy;
	assign pz = dz * dz;

	always_ff @(posedge clk) begin
		sx_s2 <= px[SQ_W-1:0];
		sy_s2 <= py[SQ_W-1:0];
		sz_s2 <= pz[SQ_W-1:0];
	end

	assign d2 = D2_W'(sx_s2) + D2_W'(sy_s2) + D2_W'(sz_s2);
	assign cmp.near = d2 <= D2_W'(cr2);
	assign cmp.far = d2 >= D2_W'(dr2);
endmodule
`default_nettype wire

@@ rtl/proximity_link_tracker_top.sv @@
// Proximity link tracker top level: device table, link memory and event sequencer.
//
// Channels: req (valid/stall) takes one command word; evt (valid/stall) gives event
// words, the final one of each command marked by last. cfg (valid/ready, always
// ready) writes connect_radius (index 0) and disconnect_radius (index 1).
// Create, ignored commands and pending destroys give one word from ST_SINGLE once
// the output register is free. Accepted updates and registered destroys walk all
// 32 slots through the link and position memories one slot per cycle, then retire
// the pipeline (ST_DRAIN) and write back the own link row (ST_WROW), with ST_LOADS
// first when the own row is loaded; then one event word per cycle while evt is not
// stalled, or a single none word when no link changed. A new command is taken once
// the last word of the previous one sits in the output register, so the slot walk
// of one command never overlaps the next.
// After reset the link memory is zeroed by a pass over all 32 slots during which
// req is stalled; configuration writes are taken as usual.
// When evt is stalled the output word holds and the sequencer waits.
`default_nettype none
module proximity_link_tracker_top import plt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire req_t req,
	output logic evt_valid,
	input wire logic evt_stall,
	output evt_t evt,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [RADIUS_W-1:0] cfg_data
);
	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_LOADS = 8'b0000_0100,
		ST_SCAN = 8'b0000_1000,
		ST_DRAIN = 8'b0001_0000,
		ST_WROW = 8'b0010_0000,
		ST_EMIT = 8'b0100_0000,
		ST_SINGLE = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [RADIUS_W-1:0] cr_q, dr_q;
	logic [2*RADIUS_W-1:0] cr2_q, dr2_q;
	logic [MAX_DEVICES-1:0] pend_q, reg_q, reader_q;
	logic [MAX_DEVICES-1:0] row_q, made_q, lost_q;
	logic [SLOT_W-1:0] slot_q, p_q, p_s1, p_s2;
	logic v_s1, v_s2;
	logic [MAX_DEVICES-1:0] rowp_s2;
	logic self_rd_q, destroy_q, drain_q;
	pos_t self_pos_q;
	evt_t single_q;

	logic [MAX_DEVICES-1:0] link_mem [MAX_DEVICES];
	logic [3*COORD_W-1:0] pos_mem [MAX_DEVICES];
	logic [MAX_DEVICES-1:0] link_rd;
	logic [3*COORD_W-1:0] pos_rd;
	logic [SLOT_W-1:0] link_ra;
	logic link_we;
	logic [SLOT_W-1:0] link_wa;
	logic [MAX_DEVICES-1:0] link_wd;

	logic accept, out_free, sb_pend, sb_reg, upd_ok;
	logic [MAX_DEVICES-1:0] self_bit;
	cmp_t cmp;
	logic do_make, do_lose;
	logic [MAX_DEVICES-1:0] emit_mask, next_made, next_lost;
	logic [SLOT_W-1:0] emit_idx;
	logic emit_made;

	assign cfg_ready = 1'b1;
	assign req_stall = state_q != ST_IDLE;
	assign accept = req_valid && !req_stall;
	assign out_free = !evt_valid || !evt_stall;
	assign sb_pend = pend_q[req.device_slot];
	assign sb_reg = reg_q[req.device_slot];
	assign upd_ok = (req.position_kind inside {POS_PREV, POS_NEXT}) &&
		(sb_pend || (sb_reg && req.position_kind == POS_NEXT));
	assign self_bit = MAX_DEVICES'(1) << slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q <= '0;
			dr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_CONNECT) cr_q <= cfg_data;
			else dr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		cr2_q <= cr_q * cr_q;
		dr2_q <= dr_q * dr_q;
	end

	always_comb begin
		link_ra = (state_q == ST_IDLE) ? req.device_slot : p_q;
	end

	always_comb begin
		link_we = 1'b0;
		link_wa = p_s2;
		link_wd = rowp_s2;
		if (state_q == ST_CLEAR) begin
			link_we = 1'b1;
			link_wa = p_q;
			link_wd = '0;
		end else if (state_q == ST_WROW) begin
			link_we = 1'b1;
			link_wa = slot_q;
			link_wd = row_q;
		end else if (v_s2 && (do_make || do_lose)) begin
			link_we = 1'b1;
			link_wd = do_make ? (rowp_s2 | self_bit) : (rowp_s2 & ~self_bit);
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		link_rd <= link_mem[link_ra];
	end

	always_ff @(posedge clk) begin
		if (accept && req.action == ACT_UPDATE && upd_ok)
			pos_mem[req.device_slot] <= {req.pos_x, req.pos_y, req.pos_z};
		pos_rd <= pos_mem[p_q];
	end

	plt_dist u_dist (
		.clk(clk),
		.self_pos(self_pos_q),
		.peer_pos(pos_t'(pos_rd)),
		.cr2(cr2_q),
		.dr2(dr2_q),
		.cmp(cmp)
	);

	always_comb begin
		do_make = 1'b0;
		do_lose = 1'b0;
		if (destroy_q) begin
			do_lose = row_q[p_s2];
		end else if (cmp.near && !row_q[p_s2]) begin
			do_make = 1'b1;
		end else if (cmp.far && row_q[p_s2]) begin
			do_lose = 1'b1;
		end
	end

	always_comb begin
		emit_made = made_q != '0;
		emit_mask = emit_made ? made_q : lost_q;
		emit_idx = lowest_idx(emit_mask);
		next_made = made_q;
		next_lost = lost_q;
		if (emit_made) next_made[emit_idx] = 1'b0;
		else next_lost[emit_idx] = 1'b0;
	end

	always_ff @(posedge clk) begin
		p_s1 <= p_q;
		p_s2 <= p_s1;
		rowp_s2 <= link_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pend_q <= '0;
			reg_q <= '0;
			reader_q <= '0;
			p_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			drain_q <= 1'b0;
			evt_valid <= 1'b0;
			made_q <= '0;
			lost_q <= '0;
			row_q <= '0;
			slot_q <= '0;
			self_rd_q <= 1'b0;
			destroy_q <= 1'b0;
			single_q <= '0;
			self_pos_q <= '0;
			evt <= '0;
		end else begin
			if (evt_valid && !evt_stall) evt_valid <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (do_make) begin
					row_q[p_s2] <= 1'b1;
					made_q[p_s2] <= 1'b1;
				end else if (do_lose) begin
					row_q[p_s2] <= 1'b0;
					lost_q[p_s2] <= 1'b1;
				end
			end
			case (state_q)
				ST_CLEAR: begin
					p_q <= p_q + 1'b1;
					if (p_q == SLOT_W'(MAX_DEVICES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						slot_q <= req.device_slot;
						self_rd_q <= reader_q[req.device_slot];
						self_pos_q <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
						single_q <= '{event_kind: EVT_NONE, reader_slot: '0,
							tag_slot: '0, last: 1'b1};
						made_q <= '0;
						lost_q <= '0;
						p_q <= '0;
						state_q <= ST_SINGLE;
						case (req.action)
							ACT_CREATE: begin
								if (sb_pend || sb_reg) begin
									single_q <= '{event_kind: EVT_DUP,
										reader_slot: req.device_slot,
										tag_slot: req.device_slot, last: 1'b1};
								end else begin
									pend_q[req.device_slot] <= 1'b1;
									reader_q[req.device_slot] <= req.reader_role;
								end
							end
							ACT_UPDATE: begin
								if (upd_ok) begin
									destroy_q <= 1'b0;
									if (sb_pend) begin
										pend_q[req.device_slot] <= 1'b0;
										reg_q[req.device_slot] <= 1'b1;
										row_q <= '0;
										state_q <= ST_SCAN;
									end else begin
										state_q <= ST_LOADS;
									end
								end
							end
							ACT_DESTROY: begin
								if (sb_pend) begin
									pend_q[req.device_slot] <= 1'b0;
									reader_q[req.device_slot] <= 1'b0;
								end else if (sb_reg) begin
									destroy_q <= 1'b1;
									state_q <= ST_LOADS;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOADS: begin
					row_q <= link_rd;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					v_s1 <= destroy_q ? row_q[p_q] :
						(reg_q[p_q] && (reader_q[p_q] != self_rd_q));
					p_q <= p_q + 1'b1;
					if (p_q == SLOT_W'(MAX_DEVICES - 1)) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) state_q <= ST_WROW;
				end
				ST_WROW: begin
					if (destroy_q) begin
						reg_q[slot_q] <= 1'b0;
						reader_q[slot_q] <= 1'b0;
					end
					state_q <= (made_q != '0 || lost_q != '0) ? ST_EMIT : ST_SINGLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						evt_valid <= 1'b1;
						evt.event_kind <= emit_made ? EVT_MADE : EVT_LOST;
						evt.reader_slot <= self_rd_q ? slot_q : emit_idx;
						evt.tag_slot <= self_rd_q ? emit_idx : slot_q;
						evt.last <= (next_made == '0) && (next_lost == '0);
						made_q <= next_made;
						lost_q <= next_lost;
						if ((next_made == '0) && (next_lost == '0)) state_q <= ST_IDLE;
					end
				end
				ST_SINGLE: begin
					if (out_free) begin
						evt_valid <= 1'b1;
						evt <= single_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_dual_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & reg_q) == '0) else $error("slot both pending and registered");

	a_made_lost_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(made_q & lost_q) == '0) else $error("pair both made and lost");

	a_emit_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && next_made == '0 && next_lost == '0)
		|=> (state_q == ST_IDLE && evt_valid && evt.last))
		else $error("final event not marked last");

	a_scan_write_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && state_q == ST_SCAN) |-> (p_s2 != p_q))
		else $error("link row write and read collide");
endmodule
`default_nettype wire

@@ tb/proximity_link_tracker_top_tb.sv @@
// Testbench for the proximity link tracker: directed and random commands, event checking.
`default_nettype none
module proximity_link_tracker_top_tb;
	import plt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic evt_valid;
	logic evt_stall;
	evt_t evt;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [RADIUS_W-1:0] cfg_data;

	proximity_link_tracker_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.evt_valid(evt_valid), .evt_stall(evt_stall), .evt(evt),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// tracker model state
	logic [15:0] conn_r, disc_r;
	logic [31:0] pend_m, reg_m, rdr_m;
	pos_t dev_pos [32];
	logic [31:0] links [32];

	evt_t pending_events [$];
	int mismatches, events_seen, items_sent, cycles;
	int send_idle_pct, recv_idle_pct;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("proximity_link_tracker_top: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			evt_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		evt_t want;
		if (arst_n && evt_valid && !evt_stall) begin
			events_seen++;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event word %h", evt);
			end else begin
				want = pending_events.pop_front();
				if (want.event_kind !== evt.event_kind || want.reader_slot !== evt.reader_slot
					|| want.tag_slot !== evt.tag_slot || want.last !== evt.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("event mismatch: expected %h got %h", want, evt);
				end
			end
		end
	end

	function automatic logic [34:0] dist_sq(int a, int b);
		longint dx, dy, dz;
		dx = longint'(dev_pos[a].x) - longint'(dev_pos[b].x);
		dy = longint'(dev_pos[a].y) - longint'(dev_pos[b].y);
		dz = longint'(dev_pos[a].z) - longint'(dev_pos[b].z);
		return 35'(dx * dx + dy * dy + dz * dz);
	endfunction

	function automatic void add_event(logic [1:0] k, int self, int peer, bit self_rdr,
		ref evt_t q[$]);
		evt_t e;
		e.event_kind = k;
		e.reader_slot = self_rdr ? 5'(self) : 5'(peer);
		e.tag_slot = self_rdr ? 5'(peer) : 5'(self);
		e.last = 1'b0;
		q.insert(q.size(), e);
	endfunction

	function automatic void relink_scan(int s, ref evt_t q[$]);
		bit self_rdr;
		logic [31:0] made, lost;
		logic [34:0] d2, c2, r2;
		self_rdr = rdr_m[s];
		c2 = 35'(conn_r) * 35'(conn_r);
		r2 = 35'(disc_r) * 35'(disc_r);
		made = '0;
		lost = '0;
		for (int p = 0; p < 32; p++) begin
			if (reg_m[p] && rdr_m[p] != self_rdr) begin
				d2 = dist_sq(s, p);
				if (d2 <= c2 && !links[s][p]) begin
					links[s][p] = 1'b1;
					links[p][s] = 1'b1;
					made[p] = 1'b1;
				end else if (d2 >= r2 && links[s][p]) begin
					links[s][p] = 1'b0;
					links[p][s] = 1'b0;
					lost[p] = 1'b1;
				end
			end
		end
		for (int p = 0; p < 32; p++)
			if (made[p]) add_event(EVT_MADE, s, p, self_rdr, q);
		for (int p = 0; p < 32; p++)
			if (lost[p]) add_event(EVT_LOST, s, p, self_rdr, q);
	endfunction

	function automatic void predict_events(req_t r);
		evt_t q[$];
		evt_t e;
		int s;
		s = r.device_slot;
		if (r.action == ACT_CREATE) begin
			if (pend_m[s] || reg_m[s]) begin
				e = '{EVT_DUP, 5'(s), 5'(s), 1'b0};
				q.insert(q.size(), e);
			end else begin
				pend_m[s] = 1'b1;
				rdr_m[s] = r.reader_role;
			end
		end else if (r.action == ACT_UPDATE
			&& (r.position_kind inside {POS_PREV, POS_NEXT})) begin
			if (pend_m[s] || (reg_m[s] && r.position_kind == POS_NEXT)) begin
				dev_pos[s] = '{r.pos_x, r.pos_y, r.pos_z};
				if (pend_m[s]) begin
					pend_m[s] = 1'b0;
					reg_m[s] = 1'b1;
					links[s] = '0;
				end
				relink_scan(s, q);
			end
		end else if (r.action == ACT_DESTROY) begin
			if (pend_m[s]) begin
				pend_m[s] = 1'b0;
				rdr_m[s] = 1'b0;
			end else if (reg_m[s]) begin
				for (int p = 0; p < 32; p++)
					if (links[s][p]) begin
						links[p][s] = 1'b0;
						add_event(EVT_LOST, s, p, rdr_m[s], q);
					end
				links[s] = '0;
				reg_m[s] = 1'b0;
				rdr_m[s] = 1'b0;
			end
		end
		if (q.size() == 0) begin
			e = '{EVT_NONE, 5'd0, 5'd0, 1'b0};
			q.insert(0, e);
		end
		q[q.size() - 1].last = 1'b1;
		foreach (q[i]) pending_events.insert(pending_events.size(), q[i]);
	endfunction

	task automatic send_cmd(logic [1:0] act, int slot, int rdr, int pk,
		int x = 0, int y = 0, int z = 0);
		req_t r;
		@(posedge clk);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		r.action = act;
		r.device_slot = 5'(slot);
		r.reader_role = 1'(rdr);
		r.position_kind = 2'(pk);
		r.pos_x = 16'(x);
		r.pos_y = 16'(y);
		r.pos_z = 16'(z);
		predict_events(r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		req_valid <= 1'b0;
		items_sent++;
	endtask

	task automatic drain();
		while (pending_events.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_radii(int c, int d);
		drain();
		cfg_index <= REG_CONNECT;
		cfg_data <= 16'(c);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_DISCONNECT;
		cfg_data <= 16'(d);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		conn_r = 16'(c);
		disc_r = 16'(d);
	endtask

	function automatic int rnd_coord(int span);
		if ($urandom_range(9) == 0) return $urandom_range(1) ? 32767 : -32768;
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic test_directed();
		write_radii(100, 200);
		send_cmd(ACT_CREATE, 0, 1, 0);
		send_cmd(ACT_CREATE, 0, 0, 0);
		send_cmd(ACT_CREATE, 31, 0, 0);
		send_cmd(ACT_UPDATE, 5, 0, POS_NEXT);
		send_cmd(ACT_UPDATE, 0, 0, 2'd0);
		send_cmd(ACT_UPDATE, 0, 0, POS_PREV, 0, 0, 0);
		send_cmd(ACT_UPDATE, 31, 0, POS_NEXT, 60, 80, 0);
		send_cmd(ACT_CREATE, 31, 1, 0);
		send_cmd(ACT_UPDATE, 31, 0, POS_PREV, 5000, 0, 0);
		send_cmd(ACT_UPDATE, 31, 0, 2'd3, 5000, 0, 0);
		send_cmd(ACT_UPDATE, 31, 0, POS_NEXT, 200, 0, 0);
		send_cmd(ACT_UPDATE, 31, 0, POS_NEXT, 150, 0, 0);
		send_cmd(ACT_UPDATE, 31, 0, POS_NEXT, 32767, 32767, 32767);
		send_cmd(ACT_UPDATE, 0, 0, POS_NEXT, -32768, -32768, -32768);
		send_cmd(2'd3, 0, 1, 2'd3);
		send_cmd(ACT_CREATE, 7, 0, 0);
		send_cmd(ACT_DESTROY, 7, 0, 0);
		send_cmd(ACT_DESTROY, 9, 0, 0);
		send_cmd(ACT_CREATE, 12, 0, 0);
		send_cmd(ACT_UPDATE, 12, 0, POS_PREV, -32768, -32768, -32767);
		send_cmd(ACT_DESTROY, 0, 0, 0);
		send_cmd(ACT_DESTROY, 12, 0, 0);
		send_cmd(ACT_DESTROY, 31, 0, 0);
	endtask

	task automatic test_random(int n, int span);
		int s, a;
		for (int i = 0; i < n; i++) begin
			s = $urandom_range(31);
			a = $urandom_range(99);
			if (a < 25) send_cmd(ACT_CREATE, s, $urandom_range(1), $urandom_range(3));
			else if (a < 80)
				send_cmd(ACT_UPDATE, s, $urandom_range(1),
					$urandom_range(9) == 0 ? $urandom_range(3) : 1 + $urandom_range(1),
					rnd_coord(span), rnd_coord(span), rnd_coord(span));
			else if (a < 95) send_cmd(ACT_DESTROY, s, $urandom_range(1), $urandom_range(3));
			else send_cmd(2'd3, s, $urandom_range(1), $urandom_range(3));
		end
	endtask

	initial begin
		arst_n = 0;
		req_valid = 0;
		req = '0;
		evt_stall = 0;
		cfg_valid = 0;
		cfg_index = REG_CONNECT;
		cfg_data = '0;
		conn_r = 0;
		disc_r = 0;
		pend_m = '0;
		reg_m = '0;
		rdr_m = '0;
		links = '{default: '0};
		dev_pos = '{default: '0};
		mismatches = 0;
		events_seen = 0;
		items_sent = 0;
		cycles = 0;
		send_idle_pct = 21;
		recv_idle_pct = 46;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(90, 300);
		send_idle_pct = 46;
		recv_idle_pct = 21;
		write_radii(0, 0);
		test_random(40, 4);
		write_radii(65535, 65535);
		test_random(40, 32768);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_radii(500, 300);
		test_random(90, 600);
		drain();
		$display("%0d commands sent, %0d event words checked over four radius settings",
			items_sent, events_seen);
		if (mismatches == 0)
			$display("proximity_link_tracker_top: match");
		else
			$display("proximity_link_tracker_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
